// File: sv/rrd_pkg.sv
// ----------------------------------------------------------------------------
// Reflectivity package
// Shared constants for the radar reflectivity datapath: species count,
// fixed-point widths, register indexes and pipeline depths.
// ----------------------------------------------------------------------------
package rrd_pkg;

   localparam int NUM_SPECIES = 6;
   localparam int K_W         = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int R_W         = 31;
   localparam int RAD_W       = 62;
   localparam int SQRT_STEPS  = 31;
   localparam int REM_W       = 33;
   localparam int Z_W         = 64;
   localparam int Z_FRAC      = 56;
   localparam int LOG_FRAC    = 24;
   localparam int EXP_W       = 7;
   localparam int MAG_W       = 31;
   localparam int PROD_W      = 63;
   localparam int DB_PROD_FRAC = LOG_FRAC + 30;

   localparam logic [Z_W-1:0] Z_MIN    = 64'd7205759;
   localparam logic [K_W-1:0] DB_SCALE = 32'd3232284966;

   localparam int LANE_LAT = 1 + SQRT_STEPS + 3;
   localparam int SUM_LAT  = 3;
   localparam int LOG_LAT  = 3 + LOG_FRAC + 3;
   localparam int TOTAL_LAT = LANE_LAT + SUM_LAT + LOG_LAT;

   localparam logic [CSR_IDX_W-1:0] CSR_K_CLOUD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_K_RAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_K_ICE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_K_SNOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_K_GRAUPEL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_K_HAIL    = 3'd5;

   localparam logic [K_W-1:0] K_CLOUD_RESET   = 32'd429497;
   localparam logic [K_W-1:0] K_RAIN_RESET    = 32'd17179869;
   localparam logic [K_W-1:0] K_ICE_RESET     = 32'd429497;
   localparam logic [K_W-1:0] K_SNOW_RESET    = 32'd4294967;
   localparam logic [K_W-1:0] K_GRAUPEL_RESET = 32'd42949673;
   localparam logic [K_W-1:0] K_HAIL_RESET    = 32'd85899346;

endpackage

// File: sv/rrd_lane.sv
// ----------------------------------------------------------------------------
// Reflectivity species lane
// Converts one mixing ratio to Q.30, takes its square root one bit per
// stage, and forms the scaled term k * q^1.5 in Q.56.
// ----------------------------------------------------------------------------
module rrd_lane #(
   parameter int RATIO_WIDTH = 32
) (
   input  logic                          clock,
   input  logic signed [RATIO_WIDTH-1:0] ratio,
   input  logic [rrd_pkg::K_W-1:0]       coef,
   output logic [rrd_pkg::Z_W-1:0]       term
);

   localparam int STEPS = rrd_pkg::SQRT_STEPS;

   logic [rrd_pkg::R_W-1:0]   r_in;
   logic [rrd_pkg::RAD_W-1:0] rad_ff  [STEPS+1];
   logic [rrd_pkg::REM_W-1:0] rem_ff  [STEPS+1];
   logic [rrd_pkg::R_W-1:0]   root_ff [STEPS+1];
   logic [rrd_pkg::R_W-1:0]   rr_ff   [STEPS+1];
   logic [61:0]               p_ff;
   logic [61:0]               a_ff;
   logic [63:0]               b_ff;
   logic [rrd_pkg::Z_W-1:0]   term_ff;
   logic [rrd_pkg::Z_W-1:0]   term_in;
   logic [32:0]               low_sum;

   generate
      if (RATIO_WIDTH >= 32) begin : g_wide
         assign r_in = ratio[RATIO_WIDTH-1] ? '0 : ratio[RATIO_WIDTH-2 -: rrd_pkg::R_W];
      end else begin : g_narrow
         assign r_in = ratio[RATIO_WIDTH-1] ? '0 :
                       {ratio[RATIO_WIDTH-2:0], {(32-RATIO_WIDTH){1'b0}}};
      end
   endgenerate

   always_ff @(posedge clock) begin
      rad_ff[0]  <= {1'b0, r_in, 30'b0};
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      rr_ff[0]   <= r_in;
   end

   genvar j;
   generate
      for (j = 0; j < STEPS; j++) begin : g_sqrt
         logic [rrd_pkg::REM_W+1:0] rem_t;
         logic [rrd_pkg::REM_W+1:0] trial;
         logic [rrd_pkg::REM_W-1:0] rem_in;
         logic [rrd_pkg::R_W-1:0]   root_in;

         always_comb begin
            rem_t = {rem_ff[j], rad_ff[j][rrd_pkg::RAD_W-1 -: 2]};
            trial = {2'b00, root_ff[j], 2'b01};
            if (rem_t >= trial) begin
               rem_in  = rrd_pkg::REM_W'(rem_t - trial);
               root_in = {root_ff[j][rrd_pkg::R_W-2:0], 1'b1};
            end else begin
               rem_in  = rrd_pkg::REM_W'(rem_t);
               root_in = {root_ff[j][rrd_pkg::R_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            rad_ff[j+1]  <= {rad_ff[j][rrd_pkg::RAD_W-3:0], 2'b00};
            rem_ff[j+1]  <= rem_in;
            root_ff[j+1] <= root_in;
            rr_ff[j+1]   <= rr_ff[j];
         end
      end
   endgenerate

   always_comb begin
      low_sum = 33'(a_ff[3:0]) + 33'(b_ff[63:32]);
      term_in = 64'(a_ff >> 4) + 64'(low_sum >> 4);
   end

   always_ff @(posedge clock) begin
      p_ff    <= 62'(rr_ff[STEPS]) * 62'(root_ff[STEPS]);
      a_ff    <= 62'(coef) * 62'(p_ff[61:32]);
      b_ff    <= 64'(coef) * 64'(p_ff[31:0]);
      term_ff <= term_in;
   end

   assign term = term_ff;

endmodule

// File: sv/rrd_sum.sv
// ----------------------------------------------------------------------------
// Reflectivity merge tree
// Adds the six lane terms in a registered tree and raises the total to the
// lower reflectivity floor.
// ----------------------------------------------------------------------------
module rrd_sum (
   input  logic                     clock,
   input  logic [rrd_pkg::Z_W-1:0]  term [rrd_pkg::NUM_SPECIES],
   output logic [rrd_pkg::Z_W-1:0]  z_out
);

   logic [rrd_pkg::Z_W-1:0] s01_ff, s23_ff, s45_ff;
   logic [rrd_pkg::Z_W-1:0] s0123_ff, s45d_ff;
   logic [rrd_pkg::Z_W-1:0] z_ff, z_in, total;

   always_comb begin
      total = s0123_ff + s45d_ff;
      z_in  = (total < rrd_pkg::Z_MIN) ? rrd_pkg::Z_MIN : total;
   end

   always_ff @(posedge clock) begin
      s01_ff   <= term[0] + term[1];
      s23_ff   <= term[2] + term[3];
      s45_ff   <= term[4] + term[5];
      s0123_ff <= s01_ff + s23_ff;
      s45d_ff  <= s45_ff;
      z_ff     <= z_in;
   end

   assign z_out = z_ff;

endmodule

// File: sv/rrd_log.sv
// ----------------------------------------------------------------------------
// Reflectivity logarithm unit
// Normalizes the sum, finds log2 by pipelined repeated squaring, scales to
// decibels, rounds and clamps to the output range.
// ----------------------------------------------------------------------------
module rrd_log #(
   parameter int OUT_FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic [rrd_pkg::Z_W-1:0]       z,
   output logic signed [7+OUT_FRAC_BITS:0] db_out
);

   localparam int OUT_W = 8 + OUT_FRAC_BITS;
   localparam int SH    = rrd_pkg::DB_PROD_FRAC - OUT_FRAC_BITS;
   localparam int NSQ   = rrd_pkg::LOG_FRAC;
   localparam logic signed [63:0] DB_LO = -64'sd30 <<< OUT_FRAC_BITS;
   localparam logic signed [63:0] DB_HI = 64'sd120 <<< OUT_FRAC_BITS;

   logic [7:0]              any_ff, any_in;
   logic [2:0]              pos_ff [8];
   logic [2:0]              pos_in [8];
   logic [rrd_pkg::Z_W-1:0] z1_ff, z2_ff;
   logic [5:0]              msb_ff, msb_in;
   logic [31:0]             m_ff [NSQ+1];
   logic [NSQ-1:0]          f_ff [NSQ+1];
   logic signed [rrd_pkg::EXP_W-1:0] e_ff [NSQ+1];
   logic [31:0]             m_norm;
   logic                    neg_ff, neg2_ff;
   logic [rrd_pkg::MAG_W-1:0] mag_ff;
   logic signed [31:0]      lg;
   logic [rrd_pkg::PROD_W-1:0] prod_ff;
   logic [63:0]             q;
   logic signed [63:0]      db;
   logic [OUT_W-1:0]        db_ff, db_in;

   always_comb begin
      for (int g = 0; g < 8; g++) begin
         any_in[g] = |z[8*g +: 8];
         pos_in[g] = 3'd0;
         for (int b = 0; b < 8; b++) begin
            if (z[8*g+b]) begin
               pos_in[g] = 3'(b);
            end
         end
      end
   end

   always_comb begin
      msb_in = 6'd0;
      for (int g = 0; g < 8; g++) begin
         if (any_ff[g]) begin
            msb_in = {3'(g), pos_ff[g]};
         end
      end
   end

   always_comb begin
      if (msb_ff >= 6'd31) begin
         m_norm = 32'(z2_ff >> (msb_ff - 6'd31));
      end else begin
         m_norm = 32'(z2_ff << (6'd31 - msb_ff));
      end
   end

   always_ff @(posedge clock) begin
      any_ff <= any_in;
      pos_ff <= pos_in;
      z1_ff  <= z;
      msb_ff <= msb_in;
      z2_ff  <= z1_ff;
      m_ff[0] <= m_norm;
      f_ff[0] <= '0;
      e_ff[0] <= $signed({1'b0, msb_ff}) - 7'sd56;
   end

   genvar i;
   generate
      for (i = 0; i < NSQ; i++) begin : g_sq
         logic [63:0] sq;
         logic [32:0] t;
         logic [31:0] m_in;
         logic [NSQ-1:0] f_in;

         always_comb begin
            sq = 64'(m_ff[i]) * 64'(m_ff[i]);
            t  = sq[63:31];
            if (t[32]) begin
               m_in = t[32:1];
               f_in = {f_ff[i][NSQ-2:0], 1'b1};
            end else begin
               m_in = t[31:0];
               f_in = {f_ff[i][NSQ-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            m_ff[i+1] <= m_in;
            f_ff[i+1] <= f_in;
            e_ff[i+1] <= e_ff[i];
         end
      end
   endgenerate

   always_comb begin
      lg = $signed({e_ff[NSQ][rrd_pkg::EXP_W-1], e_ff[NSQ], f_ff[NSQ]});
      q  = 64'(prod_ff >> SH) + 64'(prod_ff[SH-1]);
      db = neg2_ff ? -$signed(q) : $signed(q);
      if (db < DB_LO) begin
         db_in = OUT_W'(DB_LO);
      end else if (db > DB_HI) begin
         db_in = OUT_W'(DB_HI);
      end else begin
         db_in = OUT_W'(db);
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= lg[31];
      mag_ff  <= rrd_pkg::MAG_W'(lg[31] ? -lg : lg);
      prod_ff <= rrd_pkg::PROD_W'(rrd_pkg::PROD_W'(mag_ff) * rrd_pkg::PROD_W'(rrd_pkg::DB_SCALE));
      neg2_ff <= neg_ff;
      db_ff   <= db_in;
   end

   assign db_out = $signed(db_ff);

endmodule

// File: sv/radar_reflectivity_dbz_top.sv
// ----------------------------------------------------------------------------
// Radar reflectivity in dBZ
// Usage: a grid cell word is taken at each rising edge with start high and
// busy low. It carries six signed mixing ratios; negative ones count as zero.
// Six lanes form k * q^1.5 side by side, a tree merges them, and a log unit
// converts the sum to dBZ in signed Q8.OUT_FRAC_BITS, clamped to -30..120.
// The pipeline runs through the lanes (one bit of square root a stage),
// the merge tree and the log unit (one squaring a stage).
// A new word may be taken every cycle; busy is high only during reset.
// Each result shows on rsp_reflectivity_db for one cycle with rsp_valid
// high and cannot be held off by the receiver.
// The coefficients sit on the csr_ write port (indexes 0..5; higher ones
// are ignored) and should be written only while no word is in flight.
// Reset returns the coefficients to their defaults and drops any word
// still in the pipeline.
// ----------------------------------------------------------------------------
module radar_reflectivity_dbz_top #(
   parameter int RATIO_WIDTH   = 32,
   parameter int OUT_FRAC_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [RATIO_WIDTH-1:0]   req_cloud_water,
   input  logic signed [RATIO_WIDTH-1:0]   req_rain_water,
   input  logic signed [RATIO_WIDTH-1:0]   req_cloud_ice,
   input  logic signed [RATIO_WIDTH-1:0]   req_snow_ratio,
   input  logic signed [RATIO_WIDTH-1:0]   req_graupel_ratio,
   input  logic signed [RATIO_WIDTH-1:0]   req_hail_ratio,
   output logic                            rsp_valid,
   output logic signed [7+OUT_FRAC_BITS:0] rsp_reflectivity_db,
   input  logic                            csr_wr_en,
   input  logic [rrd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rrd_pkg::K_W-1:0]         csr_wr_data
);

   localparam int LAT = rrd_pkg::TOTAL_LAT;

   logic [rrd_pkg::K_W-1:0] k_ff [rrd_pkg::NUM_SPECIES];
   logic [rrd_pkg::K_W-1:0] k_in [rrd_pkg::NUM_SPECIES];
   logic signed [RATIO_WIDTH-1:0] ratio [rrd_pkg::NUM_SPECIES];
   logic [rrd_pkg::Z_W-1:0] term [rrd_pkg::NUM_SPECIES];
   logic [rrd_pkg::Z_W-1:0] z_sum;
   logic [LAT-1:0]          valid_ff, valid_in;
   logic                    accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   assign ratio[0] = req_cloud_water;
   assign ratio[1] = req_rain_water;
   assign ratio[2] = req_cloud_ice;
   assign ratio[3] = req_snow_ratio;
   assign ratio[4] = req_graupel_ratio;
   assign ratio[5] = req_hail_ratio;

   always_comb begin
      k_in = k_ff;
      if (csr_wr_en) begin
         case (csr_index)
            rrd_pkg::CSR_K_CLOUD:   k_in[0] = csr_wr_data;
            rrd_pkg::CSR_K_RAIN:    k_in[1] = csr_wr_data;
            rrd_pkg::CSR_K_ICE:     k_in[2] = csr_wr_data;
            rrd_pkg::CSR_K_SNOW:    k_in[3] = csr_wr_data;
            rrd_pkg::CSR_K_GRAUPEL: k_in[4] = csr_wr_data;
            rrd_pkg::CSR_K_HAIL:    k_in[5] = csr_wr_data;
            default:                k_in    = k_ff;
         endcase
      end
   end

   assign valid_in = {valid_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff[0]  <= rrd_pkg::K_CLOUD_RESET;
         k_ff[1]  <= rrd_pkg::K_RAIN_RESET;
         k_ff[2]  <= rrd_pkg::K_ICE_RESET;
         k_ff[3]  <= rrd_pkg::K_SNOW_RESET;
         k_ff[4]  <= rrd_pkg::K_GRAUPEL_RESET;
         k_ff[5]  <= rrd_pkg::K_HAIL_RESET;
         valid_ff <= '0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

   genvar n;
   generate
      for (n = 0; n < rrd_pkg::NUM_SPECIES; n++) begin : g_lane
         rrd_lane #(
            .RATIO_WIDTH (RATIO_WIDTH)
         ) u_lane (
            .clock (clock),
            .ratio (ratio[n]),
            .coef  (k_ff[n]),
            .term  (term[n])
         );
      end
   endgenerate

   rrd_sum u_sum (
      .clock (clock),
      .term  (term),
      .z_out (z_sum)
   );

   rrd_log #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_log (
      .clock  (clock),
      .z      (z_sum),
      .db_out (rsp_reflectivity_db)
   );

   assign rsp_valid = valid_ff[LAT-1];

`ifndef SYNTHESIS
   a_valid_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("Result word without a matching accepted word.");

   a_db_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reflectivity_db >= $signed(-(30 <<< OUT_FRAC_BITS))))
      else $error("Reflectivity below the lower clamp.");

   a_db_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reflectivity_db <= $signed(120 <<< OUT_FRAC_BITS)))
      else $error("Reflectivity above the upper clamp.");
`endif

endmodule
